// ----- design/shell_argument_tokenizer_defines.svh -----
// assertion macros used by the tokenizer command queue
// no dependencies; included by sat_queue, the only file that carries concurrent checks
`ifndef SHELL_ARGUMENT_TOKENIZER_DEFINES_SVH
`define SHELL_ARGUMENT_TOKENIZER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SAT_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SAT_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- design/sat_pkg.sv -----
// types and constants of the shell argument tokenizer
// no dependencies; imported by every tokenizer module
`default_nettype none

package sat_pkg;

   // character codes
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_TAB       = 8'h09;

   // result kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_ARG_END = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // queue between classifier and emitter
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_SPACES  = 3'd0,
      MODE_ARG     = 3'd1,
      MODE_SQUOTE  = 3'd2,
      MODE_DQUOTE  = 3'd3,
      MODE_ESC_OUT = 3'd4,
      MODE_ESC_DQ  = 3'd5
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_line;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last;
   } rsp_word_type;

   // one classified input: one or two result words
   typedef struct packed {
      logic         two;
      rsp_word_type first;
      rsp_word_type second;
   } cmd_type;

   // queue status seen by the emitter
   typedef struct packed {
      logic    empty;
      cmd_type head;
   } qstat_type;

endpackage

`default_nettype wire

// ----- design/shell_argument_tokenizer.sv -----
// Shell argument tokenizer: splits a command line into arguments, bash style.
// Input channel req_*: one word per character, or an end-of-line word that
// closes the line. Result channel rsp_*: argument bytes (kind 0), argument
// end marks (kind 1), then a done mark (kind 2) or an error mark (kind 3) if
// a quote or escape was left open; last flags the final result of each input.
// The classifier writes the command of each accepted word with results into a
// two-entry command queue; the emitter passes them through the output register.
// Throughput: one word per cycle while the queue is not full; a word with
// two results holds the output register for both of them, which the queue
// absorbs until it fills.
// Words that only change the parse mode produce no result.
// Reset (synchronous, active high) returns the parser to eating spaces and
// empties the queue and output register.
// When the receiver stalls, the current result holds; input is taken until
// the queue fills, then req_ready drops.
// Depends on sat_pkg, sat_front, sat_queue, sat_back.
`default_nettype none

module shell_argument_tokenizer
   import sat_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   cmd_type   q_cmd;
   qstat_type q_stat;

   // classifier
   sat_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   // command queue
   sat_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .stat     (q_stat)
   );

   // emitter
   sat_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

// ----- design/sat_front.sv -----
// classifier: parse mode state machine, turns each input word into a command
// depends on sat_pkg
`default_nettype none

module sat_front
   import sat_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   input  wire logic         q_full,
   output logic              q_push,
   output cmd_type           q_cmd
);

   mode_type   mode_ff, mode_in;
   logic       accept;
   logic [1:0] n_res;
   logic       is_ws;
   cmd_type    cmd;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_ws     = (req_word.in_byte == CH_SPACE) || (req_word.in_byte == CH_NEWLINE) ||
                      (req_word.in_byte == CH_TAB);

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         if (req_word.end_of_line) begin
            mode_in = MODE_SPACES;
         end else begin
            case (mode_ff)
               MODE_SQUOTE: begin
                  if (req_word.in_byte == CH_SQUOTE) mode_in = MODE_ARG;
               end
               MODE_DQUOTE: begin
                  if (req_word.in_byte == CH_DQUOTE) mode_in = MODE_ARG;
                  else if (req_word.in_byte == CH_BACKSLASH) mode_in = MODE_ESC_DQ;
               end
               MODE_ESC_OUT: mode_in = MODE_ARG;
               MODE_ESC_DQ:  mode_in = MODE_DQUOTE;
               default: begin
                  if (req_word.in_byte == CH_DQUOTE) mode_in = MODE_DQUOTE;
                  else if (req_word.in_byte == CH_SQUOTE) mode_in = MODE_SQUOTE;
                  else if (req_word.in_byte == CH_BACKSLASH) mode_in = MODE_ESC_OUT;
                  else if (is_ws) mode_in = MODE_SPACES;
                  else mode_in = MODE_ARG;
               end
            endcase
         end
      end
   end

   // result words for this input
   always_comb begin
      n_res = 2'd0;
      cmd   = '0;
      if (req_word.end_of_line) begin
         case (mode_ff)
            MODE_ARG: begin
               n_res           = 2'd2;
               cmd.first.kind  = KIND_ARG_END;
               cmd.second.kind = KIND_DONE;
            end
            MODE_SQUOTE, MODE_DQUOTE, MODE_ESC_OUT, MODE_ESC_DQ: begin
               n_res          = 2'd1;
               cmd.first.kind = KIND_ERROR;
            end
            default: begin
               n_res          = 2'd1;
               cmd.first.kind = KIND_DONE;
            end
         endcase
      end else begin
         case (mode_ff)
            MODE_SQUOTE: begin
               if (req_word.in_byte != CH_SQUOTE) begin
                  n_res              = 2'd1;
                  cmd.first.out_byte = req_word.in_byte;
               end
            end
            MODE_DQUOTE: begin
               if ((req_word.in_byte != CH_DQUOTE) && (req_word.in_byte != CH_BACKSLASH)) begin
                  n_res              = 2'd1;
                  cmd.first.out_byte = req_word.in_byte;
               end
            end
            MODE_ESC_OUT: begin
               n_res              = 2'd1;
               cmd.first.out_byte = req_word.in_byte;
            end
            MODE_ESC_DQ: begin
               // the backslash is kept unless it escapes a double quote or backslash
               if ((req_word.in_byte != CH_DQUOTE) && (req_word.in_byte != CH_BACKSLASH)) begin
                  n_res               = 2'd2;
                  cmd.first.out_byte  = CH_BACKSLASH;
                  cmd.second.out_byte = req_word.in_byte;
               end else begin
                  n_res              = 2'd1;
                  cmd.first.out_byte = req_word.in_byte;
               end
            end
            default: begin
               if ((req_word.in_byte == CH_DQUOTE) || (req_word.in_byte == CH_SQUOTE) ||
                   (req_word.in_byte == CH_BACKSLASH)) begin
                  n_res = 2'd0;
               end else if (is_ws) begin
                  if (mode_ff == MODE_ARG) begin
                     n_res          = 2'd1;
                     cmd.first.kind = KIND_ARG_END;
                  end
               end else begin
                  n_res              = 2'd1;
                  cmd.first.out_byte = req_word.in_byte;
               end
            end
         endcase
      end
      cmd.two         = (n_res == 2'd2);
      cmd.first.last  = (n_res == 2'd1);
      cmd.second.last = 1'b1;
   end

   assign q_push = accept && (n_res != 2'd0);
   assign q_cmd  = cmd;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SPACES;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/sat_queue.sv -----
// short command queue between classifier and emitter
// depends on sat_pkg and the assertion macro header
`default_nettype none

`include "shell_argument_tokenizer_defines.svh"

module sat_queue
   import sat_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output qstat_type    stat
);

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign stat.head  = slot_ff[rd_ptr_ff];

   // pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `SAT_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !full, "push into full queue")
   `SAT_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, !stat.empty, "pop from empty queue")
   `SAT_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, count_ff <= QCNT_WIDTH'(QUEUE_DEPTH),
                     "queue count out of range")
   `SAT_ASSERT_NEXT(a_count_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1,
                    "queue count did not grow on push")

endmodule

`default_nettype wire

// ----- design/sat_back.sv -----
// emitter: pops commands and sends their one or two result words
// depends on sat_pkg
`default_nettype none

module sat_back
   import sat_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire qstat_type q_stat,
   output logic           q_pop,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output rsp_word_type   rsp_word
);

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         pend_ff, pend_in;
   rsp_word_type pend_word_ff, pend_word_in;
   logic         load;

   // output register free or being drained this cycle
   assign load  = !rsp_valid_ff || rsp_ready;
   assign q_pop = load && !pend_ff && !q_stat.empty;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      pend_in      = pend_ff;
      pend_word_in = pend_word_ff;
      if (load) begin
         if (pend_ff) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = pend_word_ff;
            pend_in      = 1'b0;
         end else if (!q_stat.empty) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = q_stat.head.first;
            pend_in      = q_stat.head.two;
            pend_word_in = q_stat.head.second;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      pend_word_ff <= pend_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ----- verif/shell_argument_tokenizer_test.sv -----
// self-checking testbench of shell_argument_tokenizer: directed lines, back-to-back lines,
// then random lines, all checked word by word against a local argument splitter
// depends on sat_pkg and the tokenizer rtl
`default_nettype none

module shell_argument_tokenizer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sat_pkg::*;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   // splitter state and the words it still owes
   mode_type     shell_mode = MODE_SPACES;
   rsp_word_type expected_tokens [$];

   bit src_idle_on  = 1'b1;
   bit sink_idle_on = 1'b1;
   int words_sent    = 0;
   int lines_sent    = 0;
   int tokens_seen   = 0;
   int error_count   = 0;

   shell_argument_tokenizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_word_type token(input logic [7:0] b, input logic [1:0] k);
      rsp_word_type t;
      t.out_byte = b;
      t.kind     = k;
      t.last     = 1'b0;
      return t;
   endfunction

   // bash-style splitting of one accepted word
   function automatic void split_word(input req_word_type w);
      rsp_word_type made [$];
      logic [7:0]   ch;
      logic         blank;
      ch    = w.in_byte;
      blank = (ch == CH_SPACE) || (ch == CH_NEWLINE) || (ch == CH_TAB);
      if (w.end_of_line) begin
         case (shell_mode)
            MODE_ARG: begin
               made = {made, token(8'h00, KIND_ARG_END)};
               made = {made, token(8'h00, KIND_DONE)};
            end
            MODE_SPACES: made = {made, token(8'h00, KIND_DONE)};
            default:     made = {made, token(8'h00, KIND_ERROR)};
         endcase
         shell_mode = MODE_SPACES;
      end else begin
         case (shell_mode)
            MODE_SPACES, MODE_ARG: begin
               if (ch == CH_DQUOTE) begin
                  shell_mode = MODE_DQUOTE;
               end else if (ch == CH_SQUOTE) begin
                  shell_mode = MODE_SQUOTE;
               end else if (ch == CH_BACKSLASH) begin
                  shell_mode = MODE_ESC_OUT;
               end else if (blank) begin
                  if (shell_mode == MODE_ARG) made = {made, token(8'h00, KIND_ARG_END)};
                  shell_mode = MODE_SPACES;
               end else begin
                  made = {made, token(ch, KIND_BYTE)};
                  shell_mode = MODE_ARG;
               end
            end
            MODE_SQUOTE: begin
               if (ch == CH_SQUOTE) shell_mode = MODE_ARG;
               else made = {made, token(ch, KIND_BYTE)};
            end
            MODE_DQUOTE: begin
               if (ch == CH_DQUOTE) shell_mode = MODE_ARG;
               else if (ch == CH_BACKSLASH) shell_mode = MODE_ESC_DQ;
               else made = {made, token(ch, KIND_BYTE)};
            end
            MODE_ESC_OUT: begin
               made = {made, token(ch, KIND_BYTE)};
               shell_mode = MODE_ARG;
            end
            MODE_ESC_DQ: begin
               // backslash is kept unless it escapes a double quote or a backslash
               if (ch != CH_DQUOTE && ch != CH_BACKSLASH)
                  made = {made, token(CH_BACKSLASH, KIND_BYTE)};
               made = {made, token(ch, KIND_BYTE)};
               shell_mode = MODE_DQUOTE;
            end
            default: shell_mode = MODE_SPACES;
         endcase
      end
      if (made.size() > 0) made[made.size() - 1].last = 1'b1;
      expected_tokens = {expected_tokens, made};
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 40) $display("%0t ns mismatch: %s", $realtime, what);
   endtask

   // one input word: optional gap, then hold until accepted
   task automatic send_word(input logic [7:0] b, input logic eol);
      req_word_type w;
      int           gap;
      w.in_byte     = b;
      w.end_of_line = eol;
      gap = src_idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      split_word(w);
      words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   function automatic bit is_special(input logic [7:0] b);
      return b == CH_DQUOTE || b == CH_SQUOTE || b == CH_BACKSLASH ||
             b == CH_SPACE || b == CH_NEWLINE || b == CH_TAB;
   endfunction

   // uniform byte, but a quarter of the time one of the special characters
   function automatic logic [7:0] mixed_byte();
      logic [7:0] picks [6] = '{CH_DQUOTE, CH_SQUOTE, CH_BACKSLASH,
                                CH_SPACE, CH_NEWLINE, CH_TAB};
      if ($urandom_range(0, 3) == 0) return picks[$urandom_range(0, 5)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] byte_other_than(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] c;
      do c = mixed_byte(); while (c == a || c == b);
      return c;
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (is_special(c));
      return c;
   endfunction

   // mostly well-formed lines with random content, some broken, some noise
   task automatic send_random_line();
      int pieces;
      lines_sent++;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) send_word(mixed_byte(), 1'b0);
      end else begin
         pieces = $urandom_range(1, 6);
         repeat (pieces) begin
            case ($urandom_range(0, 5))
               0: repeat ($urandom_range(1, 4)) send_word(plain_byte(), 1'b0);
               1: repeat ($urandom_range(1, 3))
                     send_word(byte_other_than(8'h00, 8'h00) | 8'h00, 1'b0);
               2: begin
                  send_word(CH_SQUOTE, 1'b0);
                  repeat ($urandom_range(0, 4))
                     send_word(byte_other_than(CH_SQUOTE, CH_SQUOTE), 1'b0);
                  send_word(CH_SQUOTE, 1'b0);
               end
               3: begin
                  send_word(CH_DQUOTE, 1'b0);
                  repeat ($urandom_range(0, 4)) begin
                     if ($urandom_range(0, 2) == 0) begin
                        send_word(CH_BACKSLASH, 1'b0);
                        send_word(mixed_byte(), 1'b0);
                     end else begin
                        send_word(byte_other_than(CH_DQUOTE, CH_BACKSLASH), 1'b0);
                     end
                  end
                  send_word(CH_DQUOTE, 1'b0);
               end
               4: begin
                  send_word(CH_BACKSLASH, 1'b0);
                  send_word(8'($urandom_range(0, 255)), 1'b0);
               end
               default: begin
                  if ($urandom_range(0, 1) == 0) send_text("''");
                  else send_text("\"\"");
               end
            endcase
            // separate pieces by whitespace now and then
            if ($urandom_range(0, 1) == 0) send_word(CH_SPACE, 1'b0);
         end
         // leave a quote or escape open
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0: send_text("'a");
               1: send_text("\"b");
               2: send_text("\\");
               default: send_text("\"\\");
            endcase
         end
      end
      send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // extremes of the byte, every mode, empty args, kept backslash, open quotes
   task automatic test_directed_lines();
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_text("'\\'\t\"\"\n\"\\q\\\"\\\\\"\\ ");
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b1);
      send_text(" '");
      send_word(8'h00, 1'b1);
      send_text("\"");
      send_word(8'h00, 1'b1);
      send_text("\\");
      send_word(8'h00, 1'b1);
      send_text("\"\\");
      send_word(8'h00, 1'b1);
   endtask

   // no idling on either side, then a stalling receiver, so two-result words fill the queue
   task automatic test_back_to_back();
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      repeat (6) send_random_line();
      sink_idle_on = 1'b1;
      repeat (4) send_random_line();
   endtask

   // random lines, with idling switched on and off in stretches
   task automatic test_random_lines();
      int goal;
      goal = words_sent + 340;
      while (words_sent < goal) begin
         if ($urandom_range(0, 7) == 0) begin
            src_idle_on  = 1'($urandom_range(0, 1));
            sink_idle_on = 1'($urandom_range(0, 1));
         end
         send_random_line();
      end
   endtask

   // result receiver with random stalls
   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = sink_idle_on ? $urandom_range(0, 15) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // compare each accepted result with the oldest expected word
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         tokens_seen++;
         if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected word byte %02h kind %0d last %0b",
                            rsp_word.out_byte, rsp_word.kind, rsp_word.last));
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_word.out_byte !== want.out_byte || rsp_word.kind !== want.kind ||
                rsp_word.last !== want.last)
               report_mismatch($sformatf("got byte %02h kind %0d last %0b, want %02h %0d %0b",
                               rsp_word.out_byte, rsp_word.kind, rsp_word.last,
                               want.out_byte, want.kind, want.last));
         end
      end
   end

   // run limit
   initial begin
      #2_000_000;
      $display("timed out with %0d results outstanding", expected_tokens.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_lines();
      test_back_to_back();
      test_random_lines();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_tokens.size() != 0) report_mismatch("results still expected at end");
      $display("%0d words in %0d random lines plus directed lines, %0d results checked",
               words_sent, lines_sent, tokens_seen);
      $display("%0d mismatches", error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- shell_argument_tokenizer.f -----
+incdir+design
design/sat_pkg.sv
design/sat_front.sv
design/sat_queue.sv
design/sat_back.sv
design/shell_argument_tokenizer.sv
verif/shell_argument_tokenizer_test.sv
